// ===== rtl/core/max_pool_2d_window_top_defines.svh =====
`ifndef MAX_POOL_2D_WINDOW_TOP_DEFINES_SVH
`define MAX_POOL_2D_WINDOW_TOP_DEFINES_SVH

// same-cycle implication on the block clock, off while in reset
`define MP2W_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on the block clock, off while in reset
`define MP2W_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mp2w_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mp2w_pkg;

	localparam int IW_BITS        = 11;
	localparam int IH_BITS        = 13;
	localparam int PS_REG_BITS    = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 13;

	// common compare width for positions and sizes
	localparam int CMP_BITS     = 14;
	localparam int PS_BITS      = 4;
	localparam int ROW_BITS     = 12;
	localparam int HEIGHT_LIMIT = 4096;

	localparam logic [IW_BITS-1:0]     IW_RESET     = IW_BITS'(64);
	localparam logic [IH_BITS-1:0]     IH_RESET     = IH_BITS'(64);
	localparam logic [PS_REG_BITS-1:0] POOL_RESET   = PS_REG_BITS'(2);
	localparam logic [PS_REG_BITS-1:0] STRIDE_RESET = PS_REG_BITS'(2);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_POOL_HEIGHT  = 3'd2,
		REG_POOL_WIDTH   = 3'd3,
		REG_STRIDE_STEP  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic shift;
		logic capture;
	} cell_ctrl_t;

	// (a mod m) for small a, m >= 1
	function automatic logic [PS_BITS-1:0] pool_phase(input logic [PS_BITS-1:0] a,
		input logic [PS_BITS-1:0] m);
		logic [PS_BITS-1:0] rem;
		rem = a;
		for (int i = 0; i < 7; i++) begin
			if (rem >= m) begin
				rem = rem - m;
			end
		end
		return rem;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mp2w_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mp2w_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mp2w_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mp2w_cell
	import mp2w_pkg::*;
#(
	parameter int MAX_POOL   = 4,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire cell_ctrl_t                           ctrl,
	input  wire logic [MAX_POOL-1:0]                  row_mask,
	input  wire logic [MAX_POOL-1:0][PIXEL_BITS-1:0]  shift_col,
	output logic      [MAX_POOL-1:0][PIXEL_BITS-1:0]  tap_col,
	output logic      [PIXEL_BITS-1:0]                tap_max
);

	localparam logic [PIXEL_BITS-1:0] MIN_VALUE = {1'b1, {(PIXEL_BITS-1){1'b0}}};

	// one column of the window, one entry per line-store slot
	logic [MAX_POOL-1:0][PIXEL_BITS-1:0] col_q;
	logic [PIXEL_BITS-1:0]               vmax;
	logic [PIXEL_BITS-1:0]               vmax_s3;

	always_comb begin
		vmax = MIN_VALUE;
		for (int k = 0; k < MAX_POOL; k++) begin
			if (row_mask[k] && ($signed(col_q[k]) > $signed(vmax))) begin
				vmax = col_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			col_q <= shift_col;
		end
		if (ctrl.capture) begin
			vmax_s3 <= vmax;
		end
	end

	assign tap_col = col_q;
	assign tap_max = vmax_s3;

endmodule

`default_nettype wire

// ===== rtl/core/max_pool_2d_window_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming 2-D max pooling over raster-ordered planes of signed Q8.8 pixels. One pixel is
// taken every cycle; the input stalls only while a result beat waits for the sink and the
// three stages behind the output register are full. A result beat is offered once the pixel
// that closes its window has passed the line-store read at the accepting edge, the new column
// shifted into the cell row, column max inside each cell and row max across the cells into the
// output register. The line store is MAX_POOL block RAMs of MAX_WIDTH entries, one per row slot,
// each read once per pixel and only the current row's RAM written; it needs no clearing pass
// after reset. A row of MAX_POOL cells holds the last MAX_POOL columns of the window area and
// shifts by one column per pixel. tlast marks the last pooled value of a plane. Configuration
// is applied by the next pixel and should only change while no pixel is in flight.
`include "max_pool_2d_window_top_defines.svh"

module max_pool_2d_window_top
	import mp2w_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_POOL   = 4,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0]           cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]            cfg_data,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// pixel_value
	input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// pooled_value
	output logic      [((PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,
	// plane_done
	output logic                                     m_axis_tlast
);

	localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int MOD_W   = $clog2(MAX_POOL);
	localparam logic [PIXEL_BITS-1:0] MIN_VALUE = {1'b1, {(PIXEL_BITS-1){1'b0}}};

	// configuration
	logic [IW_BITS-1:0]     iw_q;
	logic [IH_BITS-1:0]     ih_q;
	logic [PS_REG_BITS-1:0] ph_q;
	logic [PS_REG_BITS-1:0] pw_q;
	logic [PS_REG_BITS-1:0] st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= IW_RESET;
			ih_q <= IH_RESET;
			ph_q <= POOL_RESET;
			pw_q <= POOL_RESET;
			st_q <= STRIDE_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:  iw_q <= cfg_data[IW_BITS-1:0];
				REG_IMAGE_HEIGHT: ih_q <= cfg_data[IH_BITS-1:0];
				REG_POOL_HEIGHT:  ph_q <= cfg_data[PS_REG_BITS-1:0];
				REG_POOL_WIDTH:   pw_q <= cfg_data[PS_REG_BITS-1:0];
				REG_STRIDE_STEP:  st_q <= cfg_data[PS_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes
	logic [CMP_BITS-1:0] iw_x, ih_x, w_eff, h_eff;
	logic [PS_BITS-1:0]  ph_x, pw_x, st_x, ph_eff, pw_eff, s_eff;

	always_comb begin
		iw_x  = CMP_BITS'(iw_q);
		ih_x  = CMP_BITS'(ih_q);
		w_eff = (iw_x == '0) ? CMP_BITS'(1) :
			(iw_x > CMP_BITS'(MAX_WIDTH)) ? CMP_BITS'(MAX_WIDTH) : iw_x;
		h_eff = (ih_x == '0) ? CMP_BITS'(1) :
			(ih_x > CMP_BITS'(HEIGHT_LIMIT)) ? CMP_BITS'(HEIGHT_LIMIT) : ih_x;
		ph_x   = PS_BITS'(ph_q);
		pw_x   = PS_BITS'(pw_q);
		st_x   = PS_BITS'(st_q);
		ph_eff = (ph_x == '0) ? PS_BITS'(1) :
			(ph_x > PS_BITS'(MAX_POOL)) ? PS_BITS'(MAX_POOL) : ph_x;
		pw_eff = (pw_x == '0) ? PS_BITS'(1) :
			(pw_x > PS_BITS'(MAX_POOL)) ? PS_BITS'(MAX_POOL) : pw_x;
		s_eff  = (st_x == '0) ? PS_BITS'(1) :
			(st_x > PS_BITS'(MAX_POOL)) ? PS_BITS'(MAX_POOL) : st_x;
	end

	// position counters; cmod_q[k] / rmod_q[k] hold column / row modulo k+1
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [MOD_W-1:0]    cmod_q [MAX_POOL];
	logic [MOD_W-1:0]    rmod_q [MAX_POOL];

	logic                acc;
	logic [CMP_BITS-1:0] c_x, r_x;
	logic [MOD_W-1:0]    s_idx, rs;
	logic                col_wrap, row_wrap;
	logic                hit_now, done_now;
	logic [PS_BITS-1:0]  d;
	logic [MAX_POOL-1:0] rmask_now, cmask_now;
	logic [PIXEL_BITS-1:0] pix;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign pix = s_axis_tdata[PIXEL_BITS-1:0];
	assign rs  = rmod_q[MAX_POOL-1];

	always_comb begin
		c_x      = CMP_BITS'(col_q);
		r_x      = CMP_BITS'(row_q);
		s_idx    = MOD_W'(s_eff - PS_BITS'(1));
		col_wrap = (c_x + CMP_BITS'(1)) >= w_eff;
		row_wrap = (r_x + CMP_BITS'(1)) >= h_eff;
		hit_now  = (r_x < h_eff) && (c_x < w_eff)
			&& ((r_x + CMP_BITS'(1)) >= CMP_BITS'(ph_eff))
			&& ((c_x + CMP_BITS'(1)) >= CMP_BITS'(pw_eff))
			&& (PS_BITS'(rmod_q[s_idx]) == pool_phase(ph_eff - PS_BITS'(1), s_eff))
			&& (PS_BITS'(cmod_q[s_idx]) == pool_phase(pw_eff - PS_BITS'(1), s_eff));
		done_now = ((r_x + CMP_BITS'(s_eff)) >= h_eff)
			&& ((c_x + CMP_BITS'(s_eff)) >= w_eff);
		// slot k holds row r - d, d = (rs - k) mod MAX_POOL
		d = '0;
		for (int k = 0; k < MAX_POOL; k++) begin
			if (PS_BITS'(rs) >= PS_BITS'(k)) begin
				d = PS_BITS'(rs) - PS_BITS'(k);
			end else begin
				d = PS_BITS'(rs) + PS_BITS'(MAX_POOL) - PS_BITS'(k);
			end
			rmask_now[k] = d < ph_eff;
			cmask_now[k] = PS_BITS'(k) < pw_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < MAX_POOL; k++) begin
				cmod_q[k] <= '0;
				rmod_q[k] <= '0;
			end
		end else if (acc) begin
			if (col_wrap) begin
				col_q <= '0;
				for (int k = 0; k < MAX_POOL; k++) begin
					cmod_q[k] <= '0;
				end
				if (row_wrap) begin
					row_q <= '0;
					for (int k = 0; k < MAX_POOL; k++) begin
						rmod_q[k] <= '0;
					end
				end else begin
					row_q <= row_q + ROW_BITS'(1);
					for (int k = 0; k < MAX_POOL; k++) begin
						rmod_q[k] <= (rmod_q[k] == MOD_W'(k)) ? '0 : rmod_q[k] + MOD_W'(1);
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				for (int k = 0; k < MAX_POOL; k++) begin
					cmod_q[k] <= (cmod_q[k] == MOD_W'(k)) ? '0 : cmod_q[k] + MOD_W'(1);
				end
			end
		end
	end

	// line store, one ram per row slot
	logic [MAX_POOL-1:0][PIXEL_BITS-1:0] ram_rd;

	for (genvar k = 0; k < MAX_POOL; k++) begin : g_store
		mp2w_ram #(
			.WIDTH (PIXEL_BITS),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (acc && (rs == MOD_W'(k))),
			.waddr (col_q),
			.wdata (pix),
			.re    (acc),
			.raddr (col_q),
			.rdata (ram_rd[k])
		);
	end

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic s1_go, s2_go, s3_go;
	logic s1_rdy, s2_rdy, s3_rdy;
	logic hit_s1, hit_s2, hit_s3;
	logic done_s1, done_s2, done_s3;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [MOD_W-1:0]      rs_s1;
	logic [MAX_POOL-1:0]   rmask_s1, rmask_s2;
	logic [MAX_POOL-1:0]   cmask_s1, cmask_s2, cmask_s3;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] pooled_q;
	logic                  last_q;

	assign s3_go  = v_s3 && (!hit_s3 || !out_valid_q || m_axis_tready);
	assign s3_rdy = !v_s3 || s3_go;
	assign s2_go  = v_s2 && s3_rdy;
	assign s2_rdy = !v_s2 || s2_go;
	assign s1_go  = v_s1 && s2_rdy;
	assign s1_rdy = !v_s1 || s1_go;
	assign s_axis_tready = s1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s1_rdy) begin
				v_s1 <= acc;
			end
			if (s2_rdy) begin
				v_s2 <= s1_go;
			end
			if (s3_rdy) begin
				v_s3 <= s2_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1   <= pix;
			rs_s1    <= rs;
			hit_s1   <= hit_now;
			done_s1  <= done_now;
			rmask_s1 <= rmask_now;
			cmask_s1 <= cmask_now;
		end
		if (s1_go) begin
			hit_s2   <= hit_s1;
			done_s2  <= done_s1;
			rmask_s2 <= rmask_s1;
			cmask_s2 <= cmask_s1;
		end
		if (s2_go) begin
			hit_s3   <= hit_s2;
			done_s3  <= done_s2;
			cmask_s3 <= cmask_s2;
		end
	end

	// new column: current row from the beat, older rows from the store
	logic [MAX_POOL-1:0][PIXEL_BITS-1:0] newcol;

	always_comb begin
		for (int k = 0; k < MAX_POOL; k++) begin
			newcol[k] = (rs_s1 == MOD_W'(k)) ? pix_s1 : ram_rd[k];
		end
	end

	// cell row, cell j holds column c - j
	cell_ctrl_t cell_ctrl;
	logic [MAX_POOL-1:0][MAX_POOL-1:0][PIXEL_BITS-1:0] cell_in;
	logic [MAX_POOL-1:0][MAX_POOL-1:0][PIXEL_BITS-1:0] tap_col;
	logic [MAX_POOL-1:0][PIXEL_BITS-1:0]               cell_max;

	assign cell_ctrl = '{shift: s1_go, capture: s2_go};

	for (genvar j = 0; j < MAX_POOL; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign cell_in[j] = newcol;
		end else begin : g_link
			assign cell_in[j] = tap_col[j-1];
		end
		mp2w_cell #(
			.MAX_POOL   (MAX_POOL),
			.PIXEL_BITS (PIXEL_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.row_mask  (rmask_s2),
			.shift_col (cell_in[j]),
			.tap_col   (tap_col[j]),
			.tap_max   (cell_max[j])
		);
	end

	logic [PIXEL_BITS-1:0] hmax;

	always_comb begin
		hmax = MIN_VALUE;
		for (int j = 0; j < MAX_POOL; j++) begin
			if (cmask_s3[j] && ($signed(cell_max[j]) > $signed(hmax))) begin
				hmax = cell_max[j];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_go && hit_s3) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go && hit_s3) begin
			pooled_q <= hmax;
			last_q   <= done_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(pooled_q);
	assign m_axis_tlast  = last_q;

	`MP2W_ASSERT_NEXT(a_result_reaches_output, v_s3 && hit_s3 && s3_go, m_axis_tvalid, "window result lost before output")
	`MP2W_ASSERT_SAME(a_no_overrun_s1, acc && v_s1, s1_go, "beat accepted over a held stage")
	`MP2W_ASSERT_SAME(a_own_row_in_window, v_s1, rmask_s1[rs_s1], "current row slot left out of window")
	`MP2W_ASSERT_SAME(a_no_result_overwrite, m_axis_tvalid && !m_axis_tready, !(s3_go && hit_s3), "waiting result overwritten")

endmodule

`default_nettype wire
